FILE: hw/rtl/c3zp_pkg.sv
// Shared types and constants for the 3x3 zero-padded convolution block.
package c3zp_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = 32;
  localparam int VALUE_W  = 35;
  localparam int DIM_W    = 11;
  localparam int COORD_W  = 10;
  localparam int KSIZE    = 3;
  localparam int KROW_W   = KSIZE * COEF_W;
  localparam int APB_AW   = 6;
  localparam int APB_DW   = 64;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_ROWS    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_COLS    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_MID    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_DRAIN  = 1'b1;

  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample;
  } c3zp_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [COORD_W-1:0]        out_row;
    logic [COORD_W-1:0]        out_col;
    logic                      frame_last;
  } c3zp_out_t;

  typedef struct packed {
    logic [DIM_W-1:0]                  frame_rows;
    logic [DIM_W-1:0]                  frame_cols;
    logic [KSIZE-1:0][KROW_W-1:0]      kernel;
  } c3zp_cfg_t;

  typedef struct packed {
    logic               has_out;
    logic               top;
    logic               bot;
    logic               left;
    logic               right;
    logic               last;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } c3zp_pos_t;

  typedef logic [KSIZE-1:0][KSIZE-1:0][SAMPLE_W-1:0] c3zp_win_t;

endpackage

FILE: hw/rtl/c3zp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module c3zp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/c3zp_ctrl.sv
// Stream position counters, word decode and first pipeline stage.
module c3zp_ctrl import c3zp_pkg::*; #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024,
  localparam int CA_W = $clog2(MAX_COLS)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       in_valid_i,
  input  c3zp_in_t                   in_word_i,
  input  c3zp_cfg_t                  cfg_i,
  input  logic                       restart_i,
  output logic                       rd_en_o,
  output logic [CA_W-1:0]            rd_addr_o,
  output logic                       s1_valid_o,
  output logic signed [SAMPLE_W-1:0] s1_sample_o,
  output logic [CA_W-1:0]            s1_addr_o,
  output c3zp_pos_t                  s1_pos_o
);

  localparam int DIM_MAX  = (1 << DIM_W) - 1;
  localparam int ROWS_CAP = (MAX_ROWS > DIM_MAX) ? DIM_MAX : MAX_ROWS;
  localparam int COLS_CAP = (MAX_COLS > DIM_MAX) ? DIM_MAX : MAX_COLS;
  localparam int P_W = $clog2(ROWS_CAP * COLS_CAP + COLS_CAP + 2);
  localparam logic [DIM_W:0] ROWS_LIM = (DIM_W + 1)'(ROWS_CAP);
  localparam logic [DIM_W:0] COLS_LIM = (DIM_W + 1)'(COLS_CAP);

  logic [DIM_W-1:0] rows_eff, cols_eff;
  logic [P_W-1:0]   total, drain_end, out_start;
  logic [P_W-1:0]   p_q, p_d;
  logic [CA_W-1:0]  j_q, j_d;
  logic [CA_W-1:0]  oc_q, oc_d;
  logic [DIM_W-1:0] or_q, or_d;
  logic             push, has_out, col_wrap, oc_end, or_end, last, fire;

  logic                       s1_valid_q;
  logic signed [SAMPLE_W-1:0] s1_sample_q;
  logic [CA_W-1:0]            s1_addr_q;
  c3zp_pos_t                  s1_pos_q;

  always_comb begin
    rows_eff = cfg_i.frame_rows;
    if (cfg_i.frame_rows == '0) begin
      rows_eff = DIM_W'(1);
    end else if ({1'b0, cfg_i.frame_rows} > ROWS_LIM) begin
      rows_eff = ROWS_LIM[DIM_W-1:0];
    end
    cols_eff = cfg_i.frame_cols;
    if (cfg_i.frame_cols == '0) begin
      cols_eff = DIM_W'(1);
    end else if ({1'b0, cfg_i.frame_cols} > COLS_LIM) begin
      cols_eff = COLS_LIM[DIM_W-1:0];
    end
  end

  assign total     = P_W'(rows_eff) * P_W'(cols_eff);
  assign drain_end = total + P_W'(cols_eff) + P_W'(1);
  assign out_start = P_W'(cols_eff) + P_W'(1);

  assign push = (in_word_i.func == FUNC_SAMPLE) ? (p_q < total)
                                                : (p_q >= total && p_q < drain_end);
  assign has_out  = p_q >= out_start;
  assign col_wrap = int'(j_q) == int'(cols_eff) - 1;
  assign oc_end   = int'(oc_q) == int'(cols_eff) - 1;
  assign or_end   = int'(or_q) == int'(rows_eff) - 1;
  assign last     = has_out && oc_end && or_end;
  assign fire     = in_valid_i && adv_i && push;

  always_comb begin
    p_d  = p_q;
    j_d  = j_q;
    oc_d = oc_q;
    or_d = or_q;
    if (restart_i || (fire && last)) begin
      p_d  = '0;
      j_d  = '0;
      oc_d = '0;
      or_d = '0;
    end else if (fire) begin
      p_d = p_q + P_W'(1);
      j_d = col_wrap ? '0 : j_q + CA_W'(1);
      if (has_out) begin
        if (oc_end) begin
          oc_d = '0;
          or_d = or_q + DIM_W'(1);
        end else begin
          oc_d = oc_q + CA_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q        <= '0;
      j_q        <= '0;
      oc_q       <= '0;
      or_q       <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      p_q  <= p_d;
      j_q  <= j_d;
      oc_q <= oc_d;
      or_q <= or_d;
      if (adv_i) begin
        s1_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_sample_q      <= (in_word_i.func == FUNC_SAMPLE) ? in_word_i.sample : '0;
      s1_addr_q        <= j_q;
      s1_pos_q.has_out <= has_out;
      s1_pos_q.top     <= (or_q == '0);
      s1_pos_q.bot     <= or_end;
      s1_pos_q.left    <= (oc_q == '0);
      s1_pos_q.right   <= oc_end;
      s1_pos_q.last    <= last;
      s1_pos_q.row     <= COORD_W'(or_q);
      s1_pos_q.col     <= COORD_W'(oc_q);
    end
  end

  assign rd_en_o     = fire;
  assign rd_addr_o   = j_q;
  assign s1_valid_o  = s1_valid_q;
  assign s1_sample_o = s1_sample_q;
  assign s1_addr_o   = s1_addr_q;
  assign s1_pos_o    = s1_pos_q;

endmodule

FILE: hw/rtl/c3zp_window.sv
// Line buffer memory with write-read forwarding and the 3x3 window registers.
module c3zp_window import c3zp_pkg::*; #(
  parameter int MAX_COLS = 1024,
  localparam int CA_W = $clog2(MAX_COLS)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       rd_en_i,
  input  logic [CA_W-1:0]            rd_addr_i,
  input  logic                       s1_valid_i,
  input  logic signed [SAMPLE_W-1:0] s1_sample_i,
  input  logic [CA_W-1:0]            s1_addr_i,
  input  c3zp_pos_t                  s1_pos_i,
  output c3zp_win_t                  win_o,
  output logic                       s2_valid_o,
  output c3zp_pos_t                  s2_pos_o
);

  localparam int LW = 2 * SAMPLE_W;

  logic [LW-1:0] ram_rdata, rd_word, wr_word, fwd_word_q;
  logic          we, fwd_q;
  logic [KSIZE-1:0][SAMPLE_W-1:0] vec;
  c3zp_win_t     win_q;
  logic          s2_valid_q;
  c3zp_pos_t     s2_pos_q;

  c3zp_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (s1_addr_i),
    .wdata_i (wr_word),
    .re_i    (rd_en_i),
    .raddr_i (rd_addr_i),
    .rdata_o (ram_rdata)
  );

  assign we      = adv_i && s1_valid_i;
  assign rd_word = fwd_q ? fwd_word_q : ram_rdata;
  assign wr_word = {rd_word[SAMPLE_W-1:0], s1_sample_i};
  assign vec[0]  = rd_word[LW-1:SAMPLE_W];
  assign vec[1]  = rd_word[SAMPLE_W-1:0];
  assign vec[2]  = s1_sample_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q      <= 1'b0;
      s2_valid_q <= 1'b0;
      win_q      <= '0;
    end else begin
      if (adv_i) begin
        fwd_q      <= we && rd_en_i && (s1_addr_i == rd_addr_i);
        s2_valid_q <= s1_valid_i && s1_pos_i.has_out;
      end
      if (we) begin
        for (int rr = 0; rr < KSIZE; rr++) begin
          for (int cc = 0; cc < KSIZE - 1; cc++) begin
            win_q[rr][cc] <= win_q[rr][cc+1];
          end
          win_q[rr][KSIZE-1] <= vec[rr];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fwd_word_q <= wr_word;
      s2_pos_q   <= s1_pos_i;
    end
  end

  assign win_o      = win_q;
  assign s2_valid_o = s2_valid_q;
  assign s2_pos_o   = s2_pos_q;

endmodule

FILE: hw/rtl/c3zp_mac.sv
// Masked products, sum of nine and the output register with skid stage.
module c3zp_mac import c3zp_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [KSIZE-1:0][KROW_W-1:0] kernel_i,
  input  c3zp_win_t                    win_i,
  input  logic                         s2_valid_i,
  input  c3zp_pos_t                    s2_pos_i,
  input  logic                         out_ready_i,
  output logic                         adv_o,
  output logic                         out_valid_o,
  output c3zp_out_t                    out_word_o
);

  logic signed [PROD_W-1:0] prod_d [KSIZE][KSIZE];
  logic signed [PROD_W-1:0] prod_q [KSIZE][KSIZE];
  logic                     s3_valid_q;
  c3zp_pos_t                s3_pos_q;
  logic signed [VALUE_W-1:0] sum;
  c3zp_out_t                res;
  logic                     out_valid_q, skid_valid_q;
  c3zp_out_t                out_q, skid_q;
  logic                     adv;

  assign adv = !skid_valid_q;

  always_comb begin
    logic signed [COEF_W-1:0]   k;
    logic signed [SAMPLE_W-1:0] s;
    logic                       mask;
    for (int rr = 0; rr < KSIZE; rr++) begin
      for (int cc = 0; cc < KSIZE; cc++) begin
        k    = kernel_i[rr][cc*COEF_W +: COEF_W];
        s    = win_i[rr][cc];
        mask = (rr == 0 && s2_pos_i.top) || (rr == KSIZE - 1 && s2_pos_i.bot) ||
               (cc == 0 && s2_pos_i.left) || (cc == KSIZE - 1 && s2_pos_i.right);
        prod_d[rr][cc] = mask ? '0 : PROD_W'(s) * PROD_W'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q   <= prod_d;
      s3_pos_q <= s2_pos_i;
    end
  end

  always_comb begin
    sum = '0;
    for (int rr = 0; rr < KSIZE; rr++) begin
      for (int cc = 0; cc < KSIZE; cc++) begin
        sum = sum + VALUE_W'(prod_q[rr][cc]);
      end
    end
  end

  always_comb begin
    res.value      = sum;
    res.out_row    = s3_pos_q.row;
    res.out_col    = s3_pos_q.col;
    res.frame_last = s3_pos_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_ready_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (s3_valid_q) begin
      if (out_valid_q && !out_ready_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_q <= skid_q;
      end
    end else if (s3_valid_q) begin
      if (out_valid_q && !out_ready_i) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign adv_o       = adv;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

FILE: hw/rtl/conv3x3_zero_padded_top.sv
// Top level: register port, stream control, line buffers, window and MAC.
// Throughput: one word per cycle while the skid stage is empty; set by the single line memory read per word.
// The skid stage lets a word be taken while one result waits on the output.
// Reset: rst_ni is asynchronous and clears counters, pipeline valids and the window;
// frame_rows and frame_cols reset to 1, kernel rows to 0; the line memory is not cleared.
module conv3x3_zero_padded_top import c3zp_pkg::*; #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  c3zp_in_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output c3zp_out_t         out_word_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int CA_W = $clog2(MAX_COLS);

  logic [DIM_W-1:0]             rows_q, cols_q;
  logic [KSIZE-1:0][KROW_W-1:0] kernel_q;
  logic [REG_IDX_W-1:0]         reg_idx;
  logic                         wr_en, restart;
  c3zp_cfg_t                    cfg;

  logic                       adv, rd_en;
  logic [CA_W-1:0]            rd_addr, s1_addr;
  logic                       s1_valid, s2_valid;
  logic signed [SAMPLE_W-1:0] s1_sample;
  c3zp_pos_t                  s1_pos, s2_pos;
  c3zp_win_t                  win;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:3];
  assign wr_en   = psel && penable && pwrite;
  assign restart = wr_en && (reg_idx == REG_FRAME_ROWS || reg_idx == REG_FRAME_COLS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= DIM_W'(1);
      cols_q   <= DIM_W'(1);
      kernel_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FRAME_ROWS:    rows_q      <= pwdata[DIM_W-1:0];
        REG_FRAME_COLS:    cols_q      <= pwdata[DIM_W-1:0];
        REG_KERNEL_TOP:    kernel_q[0] <= pwdata[KROW_W-1:0];
        REG_KERNEL_MID:    kernel_q[1] <= pwdata[KROW_W-1:0];
        REG_KERNEL_BOTTOM: kernel_q[2] <= pwdata[KROW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_ROWS:    prdata = APB_DW'(rows_q);
      REG_FRAME_COLS:    prdata = APB_DW'(cols_q);
      REG_KERNEL_TOP:    prdata = APB_DW'(kernel_q[0]);
      REG_KERNEL_MID:    prdata = APB_DW'(kernel_q[1]);
      REG_KERNEL_BOTTOM: prdata = APB_DW'(kernel_q[2]);
      default:           prdata = '0;
    endcase
  end

  assign cfg.frame_rows = rows_q;
  assign cfg.frame_cols = cols_q;
  assign cfg.kernel     = kernel_q;

  assign in_ready_o = adv;

  c3zp_ctrl #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .cfg_i       (cfg),
    .restart_i   (restart),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .s1_valid_o  (s1_valid),
    .s1_sample_o (s1_sample),
    .s1_addr_o   (s1_addr),
    .s1_pos_o    (s1_pos)
  );

  c3zp_window #(
    .MAX_COLS (MAX_COLS)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .s1_valid_i  (s1_valid),
    .s1_sample_i (s1_sample),
    .s1_addr_i   (s1_addr),
    .s1_pos_i    (s1_pos),
    .win_o       (win),
    .s2_valid_o  (s2_valid),
    .s2_pos_o    (s2_pos)
  );

  c3zp_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kernel_i    (kernel_q),
    .win_i       (win),
    .s2_valid_i  (s2_valid),
    .s2_pos_i    (s2_pos),
    .out_ready_i (out_ready_i),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

FILE: hw/rtl/c3zp_checker.sv
// Port-level checks on the output hold and input back-pressure, bound to the top level.
module c3zp_checker import c3zp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input c3zp_out_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no output word pending");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(out_valid_o && !out_ready_i))
    else $error("input stalled without an output stall");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && !out_ready_i |=> !in_ready_o)
    else $error("input stall released while output still stalled");

endmodule

bind conv3x3_zero_padded_top c3zp_checker u_checker (.*);
